// ----- src/bonf_pkg.sv -----
`default_nettype none

package bonf_pkg;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 7;
    localparam int DIMS_W     = 3;
    localparam int STATES_W   = 7;
    localparam int COUNT_W    = 7;
    localparam int MASK_W     = 64;
    localparam int FIELD_W    = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_DIMS   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_STATES = 1'b1;

    localparam logic [DIMS_W-1:0]   NUM_DIMS_RST   = 3'd1;
    localparam logic [STATES_W-1:0] NUM_STATES_RST = 7'd1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LATCH,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- src/box_overlap_neighbor_finder_top.sv -----
// Box overlap neighbor finder.
// Input channel (in_valid/in_ready) carries one command beat. A load beat
// (cmd = 0) writes the lower/upper bound of one box and dimension; a query
// beat (cmd = 1) asks which boxes below num_states overlap box state_index
// in every active dimension. Every input beat yields exactly one output beat
// on out_valid/out_ready: a load acknowledge (all zero fields) or a query
// reply with neighbor mask, count and an index error flag.
// Flow: a load or a bad query index goes from idle through ST_FINISH to the
// output register. A good query first fetches the queried box (ST_LATCH),
// then compares one stored box per cycle (ST_SCAN) through the single read
// port of the bound memory, and then goes through ST_FINISH. in_ready is high
// only while the sequencer is idle, so one item is in work at a time; the
// next beat can be taken the cycle after the result is loaded to the output.
// A stalled receiver holds the result in the output register; a finished
// item waits for it before the block returns to idle.
// After reset the bound memory is cleared one box row per cycle, rows 0 to
// MAX_STATES-1, with in_ready low. Config writes (cfg_wr_en) are taken at any
// time and must only be issued while the block is idle.
`default_nettype none

module box_overlap_neighbor_finder_top
    import bonf_pkg::*;
#(
    parameter int MAX_STATES = 64,
    parameter int MAX_DIMS   = 4,
    parameter int BOUND_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]        cfg_wdata,

    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         cmd,
    input  wire logic [5:0]                   state_index,
    input  wire logic [1:0]                   dim_index,
    input  wire logic signed [FIELD_W-1:0]    lower_bound,
    input  wire logic signed [FIELD_W-1:0]    upper_bound,

    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              is_query_reply,
    output logic [MASK_W-1:0]                 neighbor_mask,
    output logic [COUNT_W-1:0]                neighbor_count,
    output logic                              index_error
);

    localparam int SW = (BOUND_BITS < 32) ? BOUND_BITS : 32;
    localparam int JW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam logic [JW-1:0] LAST_ROW = JW'(MAX_STATES - 1);

    // bound memories: one row per box, one lane per dimension
    logic signed [SW-1:0] lo_mem [MAX_STATES][MAX_DIMS];
    logic signed [SW-1:0] up_mem [MAX_STATES][MAX_DIMS];
    logic signed [SW-1:0] rd_lo_reg [MAX_DIMS];
    logic signed [SW-1:0] rd_up_reg [MAX_DIMS];
    logic signed [SW-1:0] bi_lo_reg [MAX_DIMS];
    logic signed [SW-1:0] bi_up_reg [MAX_DIMS];

    state_t               state_reg, state_next;
    logic [JW-1:0]        clr_row_reg, clr_row_next;
    logic [JW-1:0]        cmp_j_reg, cmp_j_next;
    logic [DIMS_W-1:0]    num_dims_reg;
    logic [STATES_W-1:0]  num_states_reg;

    logic                 res_query_reg, res_query_next;
    logic [MASK_W-1:0]    res_mask_reg, res_mask_next;
    logic [COUNT_W-1:0]   res_count_reg, res_count_next;
    logic                 res_err_reg, res_err_next;

    logic                 out_valid_reg;
    logic                 out_query_reg;
    logic [MASK_W-1:0]    out_mask_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic                 out_err_reg;

    logic [JW-1:0]        rd_addr;
    logic                 mem_we;
    logic                 bi_load;
    logic                 load_out;
    logic                 load_in_range;
    logic                 query_bad;
    logic                 hit;
    logic [STATES_W-1:0]  ns_eff;
    logic [JW-1:0]        wr_row;
    logic [DW-1:0]        wr_dim;

    assign ns_eff = (num_states_reg > STATES_W'(MAX_STATES)) ? STATES_W'(MAX_STATES)
                                                               : num_states_reg;
    assign wr_row = JW'(state_index);
    assign wr_dim = DW'(dim_index);
    assign load_in_range = (STATES_W'(state_index) < STATES_W'(MAX_STATES))
                        && (4'(dim_index) < 4'(MAX_DIMS));
    assign query_bad = STATES_W'(state_index) >= ns_eff;

    // box i against box j, all active dimensions in parallel
    always_comb
    begin
        hit = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (num_dims_reg > DIMS_W'(d))
            begin
                if ((bi_up_reg[d] <= rd_lo_reg[d]) || (rd_up_reg[d] <= bi_lo_reg[d]))
                begin
                    hit = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        cmp_j_next     = cmp_j_reg;
        res_query_next = res_query_reg;
        res_mask_next  = res_mask_reg;
        res_count_next = res_count_reg;
        res_err_next   = res_err_reg;
        rd_addr        = cmp_j_reg;
        mem_we         = 1'b0;
        bi_load        = 1'b0;
        load_out       = 1'b0;
        in_ready       = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_row_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_row_next = clr_row_reg + JW'(1);
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = JW'(state_index);
                if (in_valid)
                begin
                    res_mask_next  = '0;
                    res_count_next = '0;
                    if (cmd == CMD_LOAD)
                    begin
                        mem_we         = load_in_range;
                        res_query_next = 1'b0;
                        res_err_next   = 1'b0;
                        state_next     = ST_FINISH;
                    end
                    else if (query_bad)
                    begin
                        res_query_next = 1'b1;
                        res_err_next   = 1'b1;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        res_query_next = 1'b1;
                        res_err_next   = 1'b0;
                        state_next     = ST_LATCH;
                    end
                end
            end
            ST_LATCH:
            begin
                bi_load    = 1'b1;
                rd_addr    = '0;
                cmp_j_next = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                rd_addr = cmp_j_reg + JW'(1);
                if (hit)
                begin
                    res_mask_next  = res_mask_reg | (MASK_W'(1) << cmp_j_reg);
                    res_count_next = res_count_reg + COUNT_W'(1);
                end
                if (STATES_W'(cmp_j_reg) + STATES_W'(1) == ns_eff)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmp_j_next = cmp_j_reg + JW'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_row_reg    <= '0;
            cmp_j_reg      <= '0;
            out_valid_reg  <= 1'b0;
            num_dims_reg   <= NUM_DIMS_RST;
            num_states_reg <= NUM_STATES_RST;
        end
        else
        begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            cmp_j_reg   <= cmp_j_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_NUM_DIMS:   num_dims_reg   <= cfg_wdata[DIMS_W-1:0];
                    REG_NUM_STATES: num_states_reg <= cfg_wdata[STATES_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_query_reg <= res_query_next;
        res_mask_reg  <= res_mask_next;
        res_count_reg <= res_count_next;
        res_err_reg   <= res_err_next;
        if (load_out)
        begin
            out_query_reg <= res_query_reg;
            out_mask_reg  <= res_mask_reg;
            out_count_reg <= res_count_reg;
            out_err_reg   <= res_err_reg;
        end
        if (bi_load)
        begin
            bi_lo_reg <= rd_lo_reg;
            bi_up_reg <= rd_up_reg;
        end
    end

    // bound memories: clearing pass after reset, lane writes on load
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                lo_mem[clr_row_reg][d] <= '0;
                up_mem[clr_row_reg][d] <= '0;
            end
        end
        else if (mem_we)
        begin
            lo_mem[wr_row][wr_dim] <= lower_bound[SW-1:0];
            up_mem[wr_row][wr_dim] <= upper_bound[SW-1:0];
        end
        rd_lo_reg <= lo_mem[rd_addr];
        rd_up_reg <= up_mem[rd_addr];
    end

    assign out_valid      = out_valid_reg;
    assign is_query_reply = out_query_reg;
    assign neighbor_mask  = out_mask_reg;
    assign neighbor_count = out_count_reg;
    assign index_error    = out_err_reg;

    a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> neighbor_count == COUNT_W'($countones(neighbor_mask)))
        else $error("neighbor count disagrees with mask");

    a_ack_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_query_reply) |->
            (neighbor_mask == '0 && neighbor_count == '0 && !index_error))
        else $error("load acknowledge carries data");

    a_err_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && index_error) |-> (is_query_reply && neighbor_mask == '0))
        else $error("index error reply with nonempty mask");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (STATES_W'(cmp_j_reg) < ns_eff))
        else $error("scan index past active boxes");

endmodule

`default_nettype wire
